/* hdl/srt_pkg.sv */
`timescale 1ns / 1ps

package srt_pkg;

    localparam int OP_W      = 1;
    localparam int PID_W     = 32;
    localparam int LEN_W     = 14;
    localparam int FW_W      = 32;
    localparam int STATUS_W  = 4;
    localparam int RID_W     = 12;
    localparam int OFF_W     = 26;
    localparam int MISS_W    = 12;
    localparam int TOTAL_W   = 22;
    localparam int BIT_W     = 5;
    localparam int WORD_BITS = 32;

    localparam logic [PID_W-1:0]   ID_CONNECT = '0;
    localparam logic [PID_W-1:0]   ID_CLOSE   = '1;
    localparam logic [TOTAL_W-1:0] BUF_RESET  = TOTAL_W'(2097152);

    localparam logic [OP_W-1:0] OP_HEADER = 1'b0;
    localparam logic [OP_W-1:0] OP_SCAN   = 1'b1;

    localparam logic [STATUS_W-1:0] RS_CONNECTED = 4'd0;
    localparam logic [STATUS_W-1:0] RS_ACCEPTED  = 4'd1;
    localparam logic [STATUS_W-1:0] RS_DUPLICATE = 4'd2;
    localparam logic [STATUS_W-1:0] RS_CLOSED    = 4'd3;
    localparam logic [STATUS_W-1:0] RS_RANGE     = 4'd4;
    localparam logic [STATUS_W-1:0] RS_NOCONN    = 4'd5;
    localparam logic [STATUS_W-1:0] RS_OVERFLOW  = 4'd6;
    localparam logic [STATUS_W-1:0] RS_RESEND    = 4'd7;
    localparam logic [STATUS_W-1:0] RS_ALLDONE   = 4'd8;
    localparam logic [STATUS_W-1:0] RS_MISSING   = 4'd9;

    typedef struct packed {
        logic capture;
        logic look;
        logic check;
        logic scan;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic look_done;
        logic look_scan;
        logic scan_done;
        logic out_free;
    } t_stat;

endpackage

/* hdl/srt_if.sv */
`timescale 1ns / 1ps

interface srt_in_if import srt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [PID_W-1:0]    packet_id;
    logic [LEN_W-1:0]    payload_length;
    logic [FW_W-1:0]     first_word;

    modport source (output valid, op, packet_id, payload_length, first_word, input ready);
    modport sink (input valid, op, packet_id, payload_length, first_word, output ready);
endinterface

interface srt_out_if import srt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [RID_W-1:0]    resend_id;
    logic [OFF_W-1:0]    payload_offset;
    logic [MISS_W-1:0]   missing_count;
    logic [TOTAL_W-1:0]  total_bytes;

    modport source (output valid, status, resend_id, payload_offset, missing_count,
                    total_bytes, input ready);
    modport sink (input valid, status, resend_id, payload_offset, missing_count,
                  total_bytes, output ready);
endinterface

interface srt_cfg_if import srt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [TOTAL_W-1:0]  buffer_size;

    modport source (output valid, buffer_size, input ready);
    modport sink (input valid, buffer_size, output ready);
endinterface

/* hdl/srt_ctrl.sv */
`timescale 1ns / 1ps

module srt_ctrl import srt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (i_stat.look_done) begin
                    n_state = S_DONE;
                end else if (i_stat.look_scan) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.capture = accept;
        o_cmd.look    = (r_state == S_LOOK);
        o_cmd.check   = (r_state == S_CHECK);
        o_cmd.scan    = (r_state == S_SCAN);
        o_cmd.load    = (r_state == S_DONE) && i_stat.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hdl/srt_dp.sv */
`timescale 1ns / 1ps

module srt_dp import srt_pkg::*; #(
    parameter int MAX_PACKETS    = 4096,
    parameter int PAYLOAD_STRIDE = 9000
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [OP_W-1:0]    i_op,
    input  logic [PID_W-1:0]   i_packet_id,
    input  logic [LEN_W-1:0]   i_payload_length,
    input  logic [FW_W-1:0]    i_first_word,
    srt_cfg_if.sink            i_cfg,
    srt_out_if.source          o_out
);

    localparam int ID_W   = ($clog2(MAX_PACKETS) < 6) ? 6 : $clog2(MAX_PACKETS);
    localparam int WA_W   = ID_W - BIT_W;
    localparam int WDEPTH = 1 << WA_W;
    localparam int PW     = ID_W + 1;
    localparam int SW     = $clog2(PAYLOAD_STRIDE + 1);
    localparam int CW     = (SW > LEN_W) ? SW : LEN_W;
    localparam int MW     = ID_W + SW;

    // captured item
    logic [OP_W-1:0]      r_op;
    logic [PID_W-1:0]     r_id;
    logic [LEN_W-1:0]     r_len;
    logic [FW_W-1:0]      r_fw;

    // tracker state
    logic                 r_conn,  n_conn;
    logic [ID_W-1:0]      r_exp,   n_exp;
    logic [PW-1:0]        r_ptr,   n_ptr;
    logic [TOTAL_W-1:0]   r_total, n_total;
    logic [ID_W-1:0]      r_recv,  n_recv;
    logic [WDEPTH-1:0]    r_wvld,  n_wvld;
    logic [TOTAL_W-1:0]   r_buf;

    // bitmap memory
    logic [WORD_BITS-1:0] r_mem [WDEPTH];
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_vld;
    logic [WA_W-1:0]      rd_addr;
    logic                 mem_we;
    logic [WORD_BITS-1:0] mem_wdata;

    // result staging and output register
    logic [OFF_W-1:0]     r_offset;
    logic [STATUS_W-1:0]  r_res_status, n_res_status;
    logic [RID_W-1:0]     r_res_rid,    n_res_rid;
    logic [OFF_W-1:0]     r_res_off,    n_res_off;
    logic [MISS_W-1:0]    r_res_miss,   n_res_miss;
    logic                 r_out_vld;
    logic [STATUS_W-1:0]  r_o_status;
    logic [RID_W-1:0]     r_o_rid;
    logic [OFF_W-1:0]     r_o_off;
    logic [MISS_W-1:0]    r_o_miss;
    logic [TOTAL_W-1:0]   r_o_total;

    // decode
    logic                 is_conn;
    logic [ID_W-1:0]      fw_sat;
    logic [WA_W-1:0]      id_word;
    logic [WA_W-1:0]      cw;
    logic [WA_W-1:0]      exp_w;
    logic [WORD_BITS-1:0] base;
    logic [WORD_BITS-1:0] lmask;
    logic [WORD_BITS-1:0] umask;
    logic [WORD_BITS-1:0] avail;
    logic [BIT_W-1:0]     enc;
    logic                 found;
    logic                 dup;
    logic [ID_W-1:0]      miss;
    logic [STATUS_W-1:0]  pass_status;
    logic [PW-1:0]        next_start;
    logic [ID_W-1:0]      rid_full;
    logic [CW-1:0]        len_ext;
    logic [LEN_W-1:0]     len_sat;
    logic [TOTAL_W:0]     sum;
    logic [ID_W-1:0]      idm1;
    logic [MW-1:0]        prod;
    logic                 look_done;
    logic                 scan_done;
    logic                 out_free;

    assign is_conn  = (r_op == OP_HEADER) && (r_id == ID_CONNECT);
    assign fw_sat   = (r_fw > 32'(MAX_PACKETS - 1)) ? ID_W'(MAX_PACKETS - 1) : r_fw[ID_W-1:0];
    assign id_word  = r_id[ID_W-1:BIT_W];
    assign cw       = r_ptr[ID_W-1:BIT_W];
    assign exp_w    = r_exp[ID_W-1:BIT_W];
    assign base     = r_rd_vld ? r_rd_data : '0;
    assign lmask    = {WORD_BITS{1'b1}} << r_ptr[BIT_W-1:0];
    assign umask    = (cw < exp_w) ? {WORD_BITS{1'b1}}
                    : ({WORD_BITS{1'b1}} >> (5'd31 - r_exp[BIT_W-1:0]));
    assign avail    = ~base & lmask & umask;
    assign found    = |avail;
    assign dup      = base[r_id[BIT_W-1:0]];
    assign miss     = r_exp - r_recv;
    assign pass_status = (miss == '0) ? RS_ALLDONE : RS_MISSING;
    assign next_start  = PW'({cw, {BIT_W{1'b0}}}) + PW'(WORD_BITS);
    assign rid_full = {cw, enc};
    assign len_ext  = CW'(r_len);
    assign len_sat  = (len_ext > CW'(PAYLOAD_STRIDE)) ? LEN_W'(PAYLOAD_STRIDE) : r_len;
    assign sum      = {1'b0, r_total} + (TOTAL_W + 1)'(len_sat);
    assign idm1     = r_id[ID_W-1:0] - ID_W'(1);
    assign prod     = MW'(idm1) * MW'(PAYLOAD_STRIDE);
    assign out_free = !r_out_vld || o_out.ready;

    always_comb begin
        enc = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (avail[b]) begin
                enc = BIT_W'(b);
            end
        end
    end

    always_comb begin
        n_conn       = r_conn;
        n_exp        = r_exp;
        n_ptr        = r_ptr;
        n_total      = r_total;
        n_recv       = r_recv;
        n_wvld       = r_wvld;
        n_res_status = r_res_status;
        n_res_rid    = r_res_rid;
        n_res_off    = r_res_off;
        n_res_miss   = r_res_miss;
        mem_we       = 1'b0;
        mem_wdata    = base | (WORD_BITS'(1) << r_id[BIT_W-1:0]);
        rd_addr      = (r_op == OP_SCAN) ? cw : id_word;
        look_done    = 1'b0;
        scan_done    = 1'b0;

        if (i_cmd.look) begin
            look_done  = 1'b1;
            n_res_rid  = '0;
            n_res_off  = '0;
            n_res_miss = '0;
            if (is_conn) begin
                n_conn       = 1'b1;
                n_exp        = fw_sat;
                n_ptr        = PW'(1);
                n_total      = '0;
                n_recv       = '0;
                n_wvld       = '0;
                n_res_status = RS_CONNECTED;
            end else if (!r_conn) begin
                n_res_status = RS_NOCONN;
            end else if (r_op == OP_HEADER) begin
                if (r_id == ID_CLOSE) begin
                    n_res_status = RS_CLOSED;
                end else if (r_id > PID_W'(r_exp)) begin
                    n_res_status = RS_RANGE;
                end else begin
                    look_done = 1'b0;
                end
            end else if (r_ptr > PW'(r_exp)) begin
                n_ptr        = PW'(1);
                n_res_status = pass_status;
                n_res_miss   = MISS_W'(miss);
            end else begin
                look_done = 1'b0;
            end
        end

        if (i_cmd.check) begin
            n_res_rid  = '0;
            n_res_miss = '0;
            n_res_off  = '0;
            if (dup) begin
                n_res_status = RS_DUPLICATE;
            end else begin
                mem_we           = 1'b1;
                n_wvld[id_word]  = 1'b1;
                n_recv           = r_recv + ID_W'(1);
                n_res_off        = r_offset;
                if (sum >= (TOTAL_W + 1)'(r_buf)) begin
                    n_total      = r_buf;
                    n_res_status = RS_OVERFLOW;
                end else begin
                    n_total      = sum[TOTAL_W-1:0];
                    n_res_status = RS_ACCEPTED;
                end
            end
        end

        if (i_cmd.scan) begin
            rd_addr = cw + WA_W'(1);
            if (found) begin
                scan_done    = 1'b1;
                n_ptr        = PW'(rid_full) + PW'(1);
                n_res_status = RS_RESEND;
                n_res_rid    = RID_W'(rid_full);
                n_res_off    = '0;
                n_res_miss   = '0;
            end else if (next_start > PW'(r_exp)) begin
                scan_done    = 1'b1;
                n_ptr        = PW'(1);
                n_res_status = pass_status;
                n_res_rid    = '0;
                n_res_off    = '0;
                n_res_miss   = MISS_W'(miss);
            end else begin
                n_ptr = next_start;
            end
        end
    end

    always_comb begin
        o_stat.look_done = look_done;
        o_stat.look_scan = (r_op == OP_SCAN);
        o_stat.scan_done = scan_done;
        o_stat.out_free  = out_free;
    end

    assign i_cfg.ready          = 1'b1;
    assign o_out.valid          = r_out_vld;
    assign o_out.status         = r_o_status;
    assign o_out.resend_id      = r_o_rid;
    assign o_out.payload_offset = r_o_off;
    assign o_out.missing_count  = r_o_miss;
    assign o_out.total_bytes    = r_o_total;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[id_word] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_vld  <= r_wvld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_op;
            r_id  <= i_packet_id;
            r_len <= i_payload_length;
            r_fw  <= i_first_word;
        end
        if (i_cmd.look) begin
            r_offset <= OFF_W'(prod);
        end
        r_res_status <= n_res_status;
        r_res_rid    <= n_res_rid;
        r_res_off    <= n_res_off;
        r_res_miss   <= n_res_miss;
        if (i_cmd.load) begin
            r_o_status <= r_res_status;
            r_o_rid    <= r_res_rid;
            r_o_off    <= r_res_off;
            r_o_miss   <= r_res_miss;
            r_o_total  <= r_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conn    <= 1'b0;
            r_exp     <= '0;
            r_ptr     <= PW'(1);
            r_total   <= '0;
            r_recv    <= '0;
            r_wvld    <= '0;
            r_buf     <= BUF_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_conn  <= n_conn;
            r_exp   <= n_exp;
            r_ptr   <= n_ptr;
            r_total <= n_total;
            r_recv  <= n_recv;
            r_wvld  <= n_wvld;
            if (i_cfg.valid) begin
                r_buf <= i_cfg.buffer_size;
            end
            if (i_cmd.load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    a_recv_le_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_recv <= r_exp)
        else $error("received count above expected count");

    a_ptr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr != '0)
        else $error("scan pointer at zero");

    a_noconn_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_conn |-> (r_recv == '0 && r_exp == '0))
        else $error("tracker state changed while not connected");

    a_check_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.check |=> (r_res_status == RS_DUPLICATE || r_res_status == RS_ACCEPTED
                         || r_res_status == RS_OVERFLOW))
        else $error("bitmap check produced a foreign status");

endmodule

/* hdl/selective_repeat_receive_tracker.sv */
`timescale 1ns / 1ps

// Receive-side tracker for a numbered-datagram transfer.
// i_in takes one packet header (op 0) or one resend scan step (op 1) per transfer.
// o_out returns exactly one result per input: status, resend id, payload offset,
// missing count and the running byte total. i_cfg writes buffer_size; it is always
// ready. buffer_size is to be written only while no item is in flight; the block
// itself does not enforce this. A data header passes the look and check states;
// connect, close, out of range, not connected and a scan that ends at once pass
// the look state only. A scan step walks bitmap words in the scan state, one word
// per cycle through the single read port of the bitmap RAM (up to MAX_PACKETS/32
// words). A new input is taken only after the previous result is in the output
// register.
// Reset: disconnected, byte total zero, scan pointer one, buffer_size 2097152.
// Connect clears the bitmap at once through per-word valid flags.
// A stall on o_out holds the result; one more item is then worked up to its result
// and waits until the output register frees.
module selective_repeat_receive_tracker import srt_pkg::*; #(
    parameter int MAX_PACKETS    = 4096,
    parameter int PAYLOAD_STRIDE = 9000
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srt_in_if.sink     i_in,
    srt_out_if.source  o_out,
    srt_cfg_if.sink    i_cfg
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    assign i_in.ready = w_in_ready;

    srt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    srt_dp #(
        .MAX_PACKETS    (MAX_PACKETS),
        .PAYLOAD_STRIDE (PAYLOAD_STRIDE)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_op             (i_in.op),
        .i_packet_id      (i_in.packet_id),
        .i_payload_length (i_in.payload_length),
        .i_first_word     (i_in.first_word),
        .i_cfg            (i_cfg),
        .o_out            (o_out)
    );

endmodule

/* sim/selective_repeat_receive_tracker_tb.sv */
`timescale 1ns / 1ps

module selective_repeat_receive_tracker_tb;
    import srt_pkg::*;

    localparam int MAX_PACKETS    = 4096;
    localparam int PAYLOAD_STRIDE = 9000;
    localparam int LAST_ID        = MAX_PACKETS - 1;
    localparam int IDLE_LIMIT     = 4000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int REPORT_LIMIT   = 10;
    localparam int ITEMS_PER_MODE = 300;
    localparam logic [PID_W-1:0] ID_BELOW_CLOSE = ID_CLOSE - 1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RID_W-1:0]    resend_id;
        logic [OFF_W-1:0]    payload_offset;
        logic [MISS_W-1:0]   missing_count;
        logic [TOTAL_W-1:0]  total_bytes;
    } t_tracker_result;

    class tracker_scoreboard;
        bit [MAX_PACKETS-1:0] received;
        int unsigned          expected_ids;
        int unsigned          scan_at;
        bit                   linked;
        logic [MISS_W-1:0]    requested;
        logic [TOTAL_W-1:0]   byte_sum;
        logic [TOTAL_W-1:0]   capacity;
        t_tracker_result      pending_results[$];
        int                   mismatches;

        function new();
            received     = '0;
            expected_ids = 0;
            scan_at      = 1;
            linked       = 1'b0;
            requested    = '0;
            byte_sum     = '0;
            capacity     = BUF_RESET;
            mismatches   = 0;
        endfunction

        function bit has_id(int unsigned id);
            return id < MAX_PACKETS && received[id];
        endfunction

        function void take_input(input logic [OP_W-1:0] op, input logic [PID_W-1:0] id,
                                 input logic [LEN_W-1:0] len, input logic [FW_W-1:0] fw);
            t_tracker_result r;
            int unsigned     span;
            int unsigned     i;
            int unsigned     sum;
            int unsigned     gaps;
            r = '0;
            r.status = RS_NOCONN;
            if (op == OP_HEADER && id == ID_CONNECT) begin
                received     = '0;
                received[0]  = 1'b1;
                expected_ids = (fw > LAST_ID) ? LAST_ID : fw;
                linked       = 1'b1;
                scan_at      = 1;
                requested    = '0;
                byte_sum     = '0;
                r.status     = RS_CONNECTED;
            end else if (!linked) begin
                r.status = RS_NOCONN;
            end else if (op == OP_HEADER) begin
                if (id == ID_CLOSE) begin
                    r.status = RS_CLOSED;
                end else if (id > expected_ids) begin
                    r.status = RS_RANGE;
                end else if (has_id(id)) begin
                    r.status = RS_DUPLICATE;
                end else begin
                    received[id] = 1'b1;
                    span = (len > PAYLOAD_STRIDE) ? PAYLOAD_STRIDE : len;
                    r.payload_offset = OFF_W'((id - 1) * PAYLOAD_STRIDE);
                    sum = byte_sum + span;
                    if (sum >= capacity) begin
                        byte_sum = capacity;
                        r.status = RS_OVERFLOW;
                    end else begin
                        byte_sum = TOTAL_W'(sum);
                        r.status = RS_ACCEPTED;
                    end
                end
            end else begin
                i = (scan_at == 0) ? 1 : scan_at;
                while (i <= expected_ids && has_id(i))
                    i++;
                if (i <= expected_ids) begin
                    r.resend_id = RID_W'(i);
                    r.status    = RS_RESEND;
                    scan_at     = i + 1;
                    requested   = requested + 1'b1;
                end else begin
                    gaps = 0;
                    for (i = 1; i <= expected_ids; i++)
                        if (!has_id(i))
                            gaps++;
                    r.status        = (gaps == 0) ? RS_ALLDONE : RS_MISSING;
                    r.missing_count = MISS_W'(gaps);
                    scan_at         = 1;
                    requested       = '0;
                end
            end
            r.total_bytes = byte_sum;
            pending_results.push_back(r);
        endfunction

        function void match_result(input t_tracker_result actual);
            t_tracker_result want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: status %0d rid %0d off %0d miss %0d total %0d",
                             actual.status, actual.resend_id, actual.payload_offset,
                             actual.missing_count, actual.total_bytes);
                return;
            end
            want = pending_results.pop_front();
            if (actual.status !== want.status || actual.resend_id !== want.resend_id ||
                actual.payload_offset !== want.payload_offset ||
                actual.missing_count !== want.missing_count ||
                actual.total_bytes !== want.total_bytes) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $write("mismatch: expected status %0d rid %0d off %0d miss %0d total %0d",
                           want.status, want.resend_id, want.payload_offset,
                           want.missing_count, want.total_bytes);
                    $display(" / got status %0d rid %0d off %0d miss %0d total %0d",
                             actual.status, actual.resend_id, actual.payload_offset,
                             actual.missing_count, actual.total_bytes);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    srt_in_if  in_if ();
    srt_out_if out_if ();
    srt_cfg_if cfg_if ();

    selective_repeat_receive_tracker uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    tracker_scoreboard sb;
    int in_idle_pct;
    int out_idle_pct;
    int items_sent;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        t_tracker_result seen;
        out_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_if.valid && out_if.ready) begin
                seen.status         = out_if.status;
                seen.resend_id      = out_if.resend_id;
                seen.payload_offset = out_if.payload_offset;
                seen.missing_count  = out_if.missing_count;
                seen.total_bytes    = out_if.total_bytes;
                sb.match_result(seen);
            end
            out_if.ready <= rst_n && ($urandom_range(99) >= out_idle_pct);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready) || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("** selective_repeat_receive_tracker: FAILED **");
        $finish;
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [PID_W-1:0] id,
                             input logic [LEN_W-1:0] len, input logic [FW_W-1:0] fw);
        while ($urandom_range(99) < in_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid          <= 1'b1;
        in_if.op             <= op;
        in_if.packet_id      <= id;
        in_if.payload_length <= len;
        in_if.first_word     <= fw;
        do @(posedge clk); while (!in_if.ready);
        sb.take_input(op, id, len, fw);
        items_sent++;
    endtask

    // hold off input until every pending result has drained
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do @(posedge clk); while (sb.pending_results.size() != 0);
    endtask

    task automatic write_capacity(input logic [TOTAL_W-1:0] value);
        cfg_if.valid       <= 1'b1;
        cfg_if.buffer_size <= value;
        do @(posedge clk); while (!cfg_if.ready);
        sb.capacity = value;
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return LEN_W'($urandom_range(0, 1500));
        else if (r < 85)
            return LEN_W'($urandom_range(0, PAYLOAD_STRIDE));
        else if (r < 92)
            return LEN_W'(PAYLOAD_STRIDE);
        return LEN_W'($urandom());
    endfunction

    function automatic logic [TOTAL_W-1:0] pick_capacity();
        case ($urandom_range(9))
            0: return '0;
            1: return TOTAL_W'(1);
            2: return '1;
            3: return BUF_RESET;
            4: return TOTAL_W'($urandom_range(1, 20000));
            default: return TOTAL_W'($urandom_range(9000, 400000));
        endcase
    endfunction

    function automatic logic [FW_W-1:0] pick_count();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 75)
            return FW_W'($urandom_range(1, 40));
        else if (r < 85)
            return FW_W'($urandom_range(41, 200));
        else if (r < 90)
            return '0;
        else if (r < 95)
            return $urandom_range(1) ? FW_W'(LAST_ID) : FW_W'(MAX_PACKETS);
        return FW_W'($urandom());
    endfunction

    task automatic run_transfer(input int unsigned steps);
        int unsigned       span;
        int unsigned       r;
        int unsigned       k;
        int unsigned       order[$];
        logic [FW_W-1:0]   count_word;
        count_word = pick_count();
        span = (count_word > LAST_ID) ? LAST_ID : count_word;
        send_item(OP_HEADER, ID_CONNECT, pick_length(), count_word);
        for (k = 0; k < steps; k++) begin
            r = $urandom_range(99);
            if (r < 62) begin
                send_item(OP_HEADER, (span == 0) ? $urandom_range(1, 8) : $urandom_range(1, span),
                          pick_length(), $urandom());
            end else if (r < 78) begin
                send_item(OP_SCAN, $urandom(), LEN_W'($urandom()), $urandom());
            end else if (r < 82) begin
                send_item(OP_HEADER, ID_CLOSE, pick_length(), $urandom());
            end else if (r < 88) begin
                send_item(OP_HEADER, span + 1 + $urandom_range(0, 3), pick_length(), $urandom());
            end else if (r < 93) begin
                send_item(OP_HEADER, $urandom(), LEN_W'($urandom()), $urandom());
            end else if (r < 95) begin
                send_item(OP_HEADER, ID_BELOW_CLOSE, pick_length(), $urandom());
            end else if (r < 97) begin
                wait_drained();
            end else begin
                count_word = pick_count();
                span = (count_word > LAST_ID) ? LAST_ID : count_word;
                send_item(OP_HEADER, ID_CONNECT, pick_length(), count_word);
            end
        end
        // deliver nearly every id, then walk one full resend pass
        if (span <= 64 && $urandom_range(99) < 70) begin
            order.delete();
            for (k = 1; k <= span; k++)
                if ($urandom_range(9) != 0)
                    order.push_back(k);
            order.shuffle();
            foreach (order[j])
                send_item(OP_HEADER, order[j], pick_length(), $urandom());
            repeat (span + 1)
                send_item(OP_SCAN, $urandom(), LEN_W'($urandom()), $urandom());
        end
    endtask

    initial begin
        logic [TOTAL_W-1:0] mode_capacity [3];
        int mode;
        sb = new();
        rst_n                = 1'b0;
        in_if.valid          = 1'b0;
        in_if.op             = OP_HEADER;
        in_if.packet_id      = '0;
        in_if.payload_length = '0;
        in_if.first_word     = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.buffer_size   = BUF_RESET;
        in_idle_pct          = 24;
        out_idle_pct         = 84;
        items_sent           = 0;
        mode_capacity[0]     = '1;
        mode_capacity[1]     = TOTAL_W'(1);
        mode_capacity[2]     = BUF_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        write_capacity(TOTAL_W'(18000));
        send_item(OP_SCAN, ID_CONNECT, '0, '0);
        send_item(OP_HEADER, 7, 100, '0);
        send_item(OP_HEADER, ID_CLOSE, '0, '0);
        send_item(OP_HEADER, ID_CONNECT, '0, '0);
        send_item(OP_HEADER, 1, 10, '0);
        send_item(OP_SCAN, '0, '0, '0);
        send_item(OP_HEADER, ID_CONNECT, '0, '1);
        send_item(OP_HEADER, LAST_ID, '1, '1);
        send_item(OP_HEADER, MAX_PACKETS, 1, '0);
        send_item(OP_HEADER, ID_BELOW_CLOSE, 1, '0);
        send_item(OP_HEADER, ID_CLOSE, 1, '0);
        send_item(OP_HEADER, LAST_ID, 1, '0);
        send_item(OP_SCAN, '1, '1, '1);
        send_item(OP_SCAN, '0, '0, '0);
        send_item(OP_HEADER, ID_CONNECT, '0, 3);
        send_item(OP_HEADER, 1, '0, '0);
        send_item(OP_HEADER, 2, PAYLOAD_STRIDE, '0);
        send_item(OP_HEADER, 3, PAYLOAD_STRIDE + 1, '0);
        send_item(OP_HEADER, 2, 5, '0);
        send_item(OP_SCAN, '0, '0, '0);
        send_item(OP_HEADER, ID_CONNECT, '0, 4);
        send_item(OP_HEADER, 2, 1, '0);
        repeat (4) send_item(OP_SCAN, '0, '0, '0);
        wait_drained();
        write_capacity('0);
        send_item(OP_HEADER, ID_CONNECT, '0, 2);
        send_item(OP_HEADER, 1, '0, '0);

        for (mode = 0; mode < 3; mode++) begin
            in_idle_pct  = (mode == 0) ? 24 : (mode == 1) ? 84 : 0;
            out_idle_pct = (mode == 0) ? 84 : (mode == 1) ? 24 : 0;
            wait_drained();
            write_capacity(mode_capacity[mode]);
            while (items_sent < (mode + 1) * ITEMS_PER_MODE) begin
                run_transfer($urandom_range(8, 40));
                if ($urandom_range(99) < 30) begin
                    wait_drained();
                    write_capacity(pick_capacity());
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("** selective_repeat_receive_tracker: PASSED **");
        else
            $display("** selective_repeat_receive_tracker: FAILED **");
        $finish;
    end

endmodule
